>>> rtl/label_class_indexer_defines.svh
// ---------------------------------------------------------------------------
// label_class_indexer_defines.svh
// Assertion macros used by the label class indexer top level.
// ---------------------------------------------------------------------------
`ifndef LABEL_CLASS_INDEXER_DEFINES_SVH
`define LABEL_CLASS_INDEXER_DEFINES_SVH

// Same-cycle implication, checked on clk_i, quiet while rst_ni is low
`define LCI_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("label_class_indexer: assertion failed");

// Next-cycle implication, checked on clk_i, quiet while rst_ni is low
`define LCI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("label_class_indexer: assertion failed");

`endif

>>> rtl/lci_pkg.sv
// ---------------------------------------------------------------------------
// lci_pkg
// Shared widths, register indexes and types of the label class indexer.
// ---------------------------------------------------------------------------
package lci_pkg;

  // Field widths
  localparam int unsigned LABEL_W   = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned TOL_W     = 15;
  localparam int unsigned LEN_W     = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL    = 1'b1;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0] LEN_RESET = 4'd1;
  localparam logic [TOL_W-1:0] TOL_RESET = '0;

  // Saturation limit of a class count
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Row tracking of the controller
  typedef enum logic {
    ROW_FIRST,
    ROW_MID
  } lci_row_e;

  // Controller to datapath
  typedef struct packed {
    logic adv;        // pipeline moves this cycle
    logic take;       // an input beat is accepted
    logic a_valid;    // compare stage holds an element
    logic a_start;    // that element opened a new data set
    logic a_last;     // that element closes its row
    logic b_valid;    // count stage holds a row result
    logic slot_free;  // table has an unused entry
  } lci_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit_found;  // the row in the compare stage matched a class
  } lci_stat_t;

  // One result beat
  typedef struct packed {
    logic [IDX_W-1:0]   class_index;
    logic               is_new_class;
    logic [COUNT_W-1:0] class_count;
    logic               table_full;
  } lci_res_t;

endpackage

>>> rtl/lci_label_if.sv
// ---------------------------------------------------------------------------
// lci_label_if
// Input channel: one label element per beat, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lci_label_if;
  logic                                valid;
  logic                                ready;
  logic signed [lci_pkg::LABEL_W-1:0]  label_value;
  logic                                start_of_set;

  modport source (output valid, output label_value, output start_of_set, input ready);
  modport sink   (input valid, input label_value, input start_of_set, output ready);
endinterface

>>> rtl/lci_class_if.sv
// ---------------------------------------------------------------------------
// lci_class_if
// Output channel: one row result per beat, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lci_class_if;
  logic                          valid;
  logic                          ready;
  logic [lci_pkg::IDX_W-1:0]     class_index;
  logic                          is_new_class;
  logic [lci_pkg::COUNT_W-1:0]   class_count;
  logic                          table_full;

  modport source (output valid, output class_index, output is_new_class,
                  output class_count, output table_full, input ready);
  modport sink   (input valid, input class_index, input is_new_class,
                  input class_count, input table_full, output ready);
endinterface

>>> rtl/lci_ram.sv
// ---------------------------------------------------------------------------
// lci_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lci_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port (read returns old data on a collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lci_ctrl.sv
// ---------------------------------------------------------------------------
// lci_ctrl
// Row sequencing, pipeline valids, stall control and class occupancy.
// ---------------------------------------------------------------------------
module lci_ctrl #(
  parameter int unsigned MAX_CLASSES   = 16,
  parameter int unsigned MAX_LABEL_LEN = 8,
  parameter int unsigned PW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1,
  parameter int unsigned UW = $clog2(MAX_CLASSES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_start_i,
  input  logic                        out_ready_i,
  input  logic [lci_pkg::LEN_W-1:0]   label_length_i,
  input  lci_pkg::lci_stat_t          stat_i,
  output lci_pkg::lci_cmd_t           cmd_o,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  output logic [PW-1:0]               rd_pos_o,
  output logic [PW-1:0]               a_pos_o,
  output logic [UW-1:0]               used_o
);

  localparam int unsigned LW = $clog2(MAX_LABEL_LEN + 1);
  localparam int unsigned XW = ((LW > lci_pkg::LEN_W) ? LW : lci_pkg::LEN_W) + 1;

  lci_pkg::lci_row_e state_q, state_d;
  logic [PW-1:0] pos_q;
  logic          a_valid_q, a_start_q, a_last_q, b_valid_q;
  logic [PW-1:0] a_pos_q;
  logic [UW-1:0] used_q;

  logic          adv, take, in_last, slot_free;
  logic [PW-1:0] in_pos;
  logic [XW-1:0] len_raw, len_eff;
  logic [UW-1:0] used_eff;

  // Stall only when a finished result is not taken
  assign adv  = !(b_valid_q && !out_ready_i);
  assign take = in_valid_i && adv;

  // Effective row length: zero acts as one, clipped to the buffer depth
  assign len_raw = XW'(label_length_i);
  always_comb begin
    if (len_raw == '0) begin
      len_eff = XW'(1);
    end else if (len_raw > XW'(MAX_LABEL_LEN)) begin
      len_eff = XW'(MAX_LABEL_LEN);
    end else begin
      len_eff = len_raw;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    if (take) begin
      state_d = in_last ? lci_pkg::ROW_FIRST : lci_pkg::ROW_MID;
    end
  end

  // Outputs: position of the incoming element and its row-end flag
  always_comb begin
    unique case (state_q)
      lci_pkg::ROW_FIRST: in_pos = '0;
      lci_pkg::ROW_MID:   in_pos = in_start_i ? '0 : pos_q;
      default:            in_pos = '0;
    endcase
    in_last = (XW'(in_pos) + XW'(1)) >= len_eff;
  end

  // A start in the compare stage empties the table for that element
  assign used_eff  = a_start_q ? '0 : used_q;
  assign slot_free = used_eff < UW'(MAX_CLASSES);

  // State, position and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lci_pkg::ROW_FIRST;
      pos_q   <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        pos_q <= in_pos + PW'(1);
      end
      if (adv && a_valid_q) begin
        if (a_last_q && !stat_i.hit_found && slot_free) begin
          used_q <= used_eff + UW'(1);
        end else begin
          used_q <= used_eff;
        end
      end
    end
  end

  // Pipeline stage tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_start_q <= 1'b0;
      a_last_q  <= 1'b0;
      a_pos_q   <= '0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= take;
      b_valid_q <= a_valid_q && a_last_q;
      if (take) begin
        a_start_q <= in_start_i;
        a_last_q  <= in_last;
        a_pos_q   <= in_pos;
      end
    end
  end

  // Command bundle
  always_comb begin
    cmd_o.adv       = adv;
    cmd_o.take      = take;
    cmd_o.a_valid   = a_valid_q;
    cmd_o.a_start   = a_start_q;
    cmd_o.a_last    = a_last_q;
    cmd_o.b_valid   = b_valid_q;
    cmd_o.slot_free = slot_free;
  end

  // Stalled: re-read the element held in the compare stage
  assign rd_pos_o    = adv ? in_pos : a_pos_q;
  assign a_pos_o     = a_pos_q;
  assign used_o      = used_eff;
  assign in_ready_o  = adv;
  assign out_valid_o = b_valid_q;

endmodule

>>> rtl/lci_datapath.sv
// ---------------------------------------------------------------------------
// lci_datapath
// Per-class element stores and compare lanes, match mask, first-match pick
// and the saturating class counters.
// ---------------------------------------------------------------------------
module lci_datapath #(
  parameter int unsigned MAX_CLASSES   = 16,
  parameter int unsigned MAX_LABEL_LEN = 8,
  parameter int unsigned PW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1,
  parameter int unsigned UW = $clog2(MAX_CLASSES + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lci_pkg::lci_cmd_t                  cmd_i,
  input  logic [PW-1:0]                      rd_pos_i,
  input  logic [PW-1:0]                      a_pos_i,
  input  logic [UW-1:0]                      used_i,
  input  logic signed [lci_pkg::LABEL_W-1:0] label_value_i,
  input  logic [lci_pkg::TOL_W-1:0]          tol_i,
  output lci_pkg::lci_stat_t                 stat_o,
  output lci_pkg::lci_res_t                  res_o
);

  localparam int unsigned N  = MAX_CLASSES;
  localparam int unsigned CW = $clog2(MAX_CLASSES);
  localparam int unsigned DW = lci_pkg::LABEL_W + 1;
  localparam int unsigned IW = lci_pkg::IDX_W;

  // Compare stage element
  logic signed [lci_pkg::LABEL_W-1:0] v_a_q;

  // Store write / bypass
  logic                        st_we;
  logic [CW-1:0]               slot;
  logic                        sfwd_valid_q;
  logic [CW-1:0]               sfwd_slot_q;
  logic [lci_pkg::LABEL_W-1:0] sfwd_data_q;

  logic [lci_pkg::LABEL_W-1:0] lane_rd   [N];
  logic [lci_pkg::LABEL_W-1:0] lane_data [N];
  logic [N-1:0]                lane_ok, lane_act;
  logic [N-1:0]                mask_q, mask_cur, mask_new, cand;
  logic [CW-1:0]               hit_idx;
  logic                        hit_found;

  // Count stage
  logic [CW-1:0]                idx_b_q;
  logic                         new_b_q, full_b_q;
  logic                         cnt_we;
  logic [CW-1:0]                cnt_raddr;
  logic [lci_pkg::COUNT_W-1:0]  cnt_rd, cnt_old, cnt_b;
  logic                         cfwd_valid_q;
  logic [lci_pkg::COUNT_W-1:0]  cfwd_data_q;
  logic [CW+IW-1:0]             idx_wide;

  // Capture the accepted element
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      v_a_q <= label_value_i;
    end
  end

  // Each element goes straight into the next free entry; it only counts
  // as a class if the row ends without a match
  assign slot  = used_i[CW-1:0];
  assign st_we = cmd_i.adv && cmd_i.a_valid && cmd_i.slot_free;

  // Bypass for a read that collides with this cycle's write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfwd_valid_q <= 1'b0;
    end else begin
      sfwd_valid_q <= st_we && (a_pos_i == rd_pos_i);
    end
  end

  always_ff @(posedge clk_i) begin
    sfwd_slot_q <= slot;
    sfwd_data_q <= v_a_q;
  end

  assign mask_cur = cmd_i.a_start ? '1 : mask_q;

  // One store and one compare lane per class
  for (genvar k = 0; k < N; k++) begin : g_lane
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        adiff;

    lci_ram #(
      .WIDTH (lci_pkg::LABEL_W),
      .DEPTH (MAX_LABEL_LEN)
    ) u_store (
      .clk_i   (clk_i),
      .we_i    (st_we && (slot == CW'(k))),
      .waddr_i (a_pos_i),
      .wdata_i (v_a_q),
      .raddr_i (rd_pos_i),
      .rdata_o (lane_rd[k])
    );

    assign lane_data[k] = (sfwd_valid_q && (sfwd_slot_q == CW'(k))) ? sfwd_data_q
                                                                     : lane_rd[k];
    assign diff  = $signed({v_a_q[lci_pkg::LABEL_W-1], v_a_q})
                 - $signed({lane_data[k][lci_pkg::LABEL_W-1], lane_data[k]});
    assign adiff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign lane_ok[k]  = adiff <= DW'(tol_i);
    assign lane_act[k] = UW'(k) < used_i;
    assign mask_new[k] = mask_cur[k] && lane_ok[k];
    assign cand[k]     = lane_act[k] && mask_new[k];
  end

  // Lowest-numbered surviving class wins
  always_comb begin
    hit_idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (cand[k]) begin
        hit_idx = CW'(k);
      end
    end
  end
  assign hit_found        = |cand;
  assign stat_o.hit_found = hit_found;

  // Match mask and row decision
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (cmd_i.adv && cmd_i.a_valid) begin
      mask_q <= cmd_i.a_last ? '1 : mask_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv && cmd_i.a_valid && cmd_i.a_last) begin
      new_b_q  <= !hit_found && cmd_i.slot_free;
      full_b_q <= !hit_found && !cmd_i.slot_free;
      if (hit_found) begin
        idx_b_q <= hit_idx;
      end else if (cmd_i.slot_free) begin
        idx_b_q <= slot;
      end else begin
        idx_b_q <= '0;
      end
    end
  end

  // Class counters
  assign cnt_raddr = cmd_i.adv ? hit_idx : idx_b_q;
  assign cnt_we    = cmd_i.adv && cmd_i.b_valid && !full_b_q;

  lci_ram #(
    .WIDTH (lci_pkg::COUNT_W),
    .DEPTH (MAX_CLASSES)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (idx_b_q),
    .wdata_i (cnt_b),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfwd_valid_q <= 1'b0;
    end else begin
      cfwd_valid_q <= cnt_we && (idx_b_q == cnt_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    cfwd_data_q <= cnt_b;
  end

  // Saturating increment, one for a new class, or zero for a full table
  assign cnt_old = cfwd_valid_q ? cfwd_data_q : cnt_rd;
  always_comb begin
    if (full_b_q) begin
      cnt_b = '0;
    end else if (new_b_q) begin
      cnt_b = lci_pkg::COUNT_W'(1);
    end else if (cnt_old == lci_pkg::COUNT_MAX) begin
      cnt_b = cnt_old;
    end else begin
      cnt_b = cnt_old + lci_pkg::COUNT_W'(1);
    end
  end

  // Result beat; index masked to the field width
  assign idx_wide = {{IW{1'b0}}, idx_b_q};
  always_comb begin
    res_o.class_index  = idx_wide[IW-1:0];
    res_o.is_new_class = new_b_q;
    res_o.class_count  = cnt_b;
    res_o.table_full   = full_b_q;
  end

endmodule

>>> rtl/label_class_indexer.sv
// ---------------------------------------------------------------------------
// label_class_indexer
// Streaming table of distinct label vectors matched with a tolerance.
// ---------------------------------------------------------------------------
// Takes one signed Q8.8 label element per beat; every element is compared at
// once against the same position of all stored classes, one compare lane and
// one small element RAM per class. An element is accepted every cycle; the
// input stalls only while a row result sits on the output unaccepted. The
// result of a row passes the compare stage, fed by the registered read of
// the class RAMs, and then the count stage, fed by the registered read of
// the count RAM. No clearing pass is needed after reset or a start of set:
// the occupancy count alone decides which entries are live.
`include "label_class_indexer_defines.svh"

module label_class_indexer #(
  parameter int unsigned MAX_CLASSES   = 16,
  parameter int unsigned MAX_LABEL_LEN = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lci_label_if.sink                        label_i,
  lci_class_if.source                      class_o,
  input  logic                             cfg_we_i,
  input  logic [lci_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lci_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned PW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1;
  localparam int unsigned UW = $clog2(MAX_CLASSES + 1);

  logic [lci_pkg::LEN_W-1:0] len_q;
  logic [lci_pkg::TOL_W-1:0] tol_q;

  lci_pkg::lci_cmd_t  cmd;
  lci_pkg::lci_stat_t stat;
  lci_pkg::lci_res_t  res;
  logic [PW-1:0]      rd_pos, a_pos;
  logic [UW-1:0]      used;
  logic               in_ready, out_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= lci_pkg::LEN_RESET;
      tol_q <= lci_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lci_pkg::CFG_LABEL_LENGTH: len_q <= cfg_data_i[lci_pkg::LEN_W-1:0];
        lci_pkg::CFG_MATCH_TOL:    tol_q <= cfg_data_i[lci_pkg::TOL_W-1:0];
        default:                   len_q <= len_q;
      endcase
    end
  end

  lci_ctrl #(
    .MAX_CLASSES   (MAX_CLASSES),
    .MAX_LABEL_LEN (MAX_LABEL_LEN),
    .PW            (PW),
    .UW            (UW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (label_i.valid),
    .in_start_i     (label_i.start_of_set),
    .out_ready_i    (class_o.ready),
    .label_length_i (len_q),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .in_ready_o     (in_ready),
    .out_valid_o    (out_valid),
    .rd_pos_o       (rd_pos),
    .a_pos_o        (a_pos),
    .used_o         (used)
  );

  lci_datapath #(
    .MAX_CLASSES   (MAX_CLASSES),
    .MAX_LABEL_LEN (MAX_LABEL_LEN),
    .PW            (PW),
    .UW            (UW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_pos_i      (rd_pos),
    .a_pos_i       (a_pos),
    .used_i        (used),
    .label_value_i (label_i.label_value),
    .tol_i         (tol_q),
    .stat_o        (stat),
    .res_o         (res)
  );

  // Channel hookup
  assign label_i.ready        = in_ready;
  assign class_o.valid        = out_valid;
  assign class_o.class_index  = res.class_index;
  assign class_o.is_new_class = res.is_new_class;
  assign class_o.class_count  = res.class_count;
  assign class_o.table_full   = res.table_full;

  // Checks
  `LCI_ASSERT_IMPL(a_full_result_zero, out_valid && res.table_full, (res.class_index == '0) && (res.class_count == '0) && !res.is_new_class)
  `LCI_ASSERT_IMPL(a_new_class_one, out_valid && res.is_new_class, (res.class_count == lci_pkg::COUNT_W'(1)) && !res.table_full)
  `LCI_ASSERT_IMPL(a_used_in_range, cmd.a_valid, used <= UW'(MAX_CLASSES))
  `LCI_ASSERT_IMPL(a_stall_no_take, out_valid && !class_o.ready, !cmd.take)
  `LCI_ASSERT_NEXT(a_hold_result, out_valid && !class_o.ready, out_valid && $stable(res))

endmodule

>>> tb/tb_label_class_indexer.sv
// ---------------------------------------------------------------------------
// tb_label_class_indexer
// Self-checking bench for the label class indexer.
// ---------------------------------------------------------------------------
// Label elements stream in on the input channel from a backlog queue. Every
// accepted beat goes through a cycle-free model of the class table, which
// queues the row result it expects. The output monitor checks each result
// beat against the oldest queued one. A short directed part covers reset
// values, a full table, the widest element differences, a length change in
// mid-row and a zero length. Random phases follow under a spread of
// lengths and tolerances and several sender/receiver idle mixes, one with a
// long output hold.
// ---------------------------------------------------------------------------
module tb_label_class_indexer;
  import lci_pkg::*;

  localparam int NCLS        = 16;
  localparam int NLEN        = 8;
  localparam int LAT_CYCLES  = 6;       // quiet cycles before a register write
  localparam int HOLD_CYCLES = 300;     // long output hold-off
  localparam int TIMEOUT     = 8 * 1_000_000;

  typedef struct packed {
    logic [LABEL_W-1:0] value;
    logic               sos;
  } label_beat_t;

  typedef logic [NLEN-1:0][LABEL_W-1:0] row_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // Bench-side drive of the block inputs, known from time zero
  logic                 drv_valid  = 1'b0;
  logic [LABEL_W-1:0]   drv_value  = '0;
  logic                 drv_sos    = 1'b0;
  logic                 rcv_ready  = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lci_label_if label_bus ();
  lci_class_if class_bus ();

  assign label_bus.valid        = drv_valid;
  assign label_bus.label_value  = drv_value;
  assign label_bus.start_of_set = drv_sos;
  assign class_bus.ready        = rcv_ready;

  label_class_indexer #(
    .MAX_CLASSES  (NCLS),
    .MAX_LABEL_LEN(NLEN)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .label_i   (label_bus),
    .class_o   (class_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Stimulus and expectation stores
  label_beat_t label_backlog[$];
  lci_res_t    expected_classes[$];

  // Idle control, set between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_seen;
  int unsigned hold_left;

  // Bookkeeping
  int unsigned fail_count     = 0;
  int unsigned beats_in       = 0;
  int unsigned rows_new       = 0;
  int unsigned rows_matched   = 0;
  int unsigned rows_full      = 0;
  int unsigned rows_saturated = 0;
  int unsigned cfg_writes     = 0;

  // Class table model
  logic [LABEL_W-1:0] cls_vec [NCLS][NLEN];
  logic [COUNT_W-1:0] cls_cnt [NCLS];
  logic [LABEL_W-1:0] row_buf [NLEN];
  logic [NCLS-1:0]    cand_mask = '1;
  int unsigned        cls_used  = 0;
  int unsigned        elem_pos  = 0;
  logic [LEN_W-1:0]   cfg_len   = LEN_RESET;
  logic [TOL_W-1:0]   cfg_tol   = TOL_RESET;

  // Generator view
  int unsigned gen_len     = 1;
  logic        force_start = 1'b0;
  row_t        palette[$];

  initial begin
    for (int j = 0; j < NLEN; j++) row_buf[j] = '0;
    for (int k = 0; k < NCLS; k++) begin
      cls_cnt[k] = '0;
      for (int j = 0; j < NLEN; j++) cls_vec[k][j] = '0;
    end
  end

  // Take one accepted element into the class table model
  task automatic classify_element(input logic [LABEL_W-1:0] v, input logic sos);
    int unsigned len, pos, hit, ad;
    int d;
    lci_res_t res;
    len = (cfg_len == 0) ? 1 : ((cfg_len > NLEN) ? NLEN : int'(cfg_len));
    if (sos) begin
      cls_used  = 0;
      elem_pos  = 0;
      cand_mask = '1;
    end
    pos = (elem_pos >= NLEN) ? NLEN - 1 : elem_pos;
    row_buf[pos] = v;
    for (int k = 0; k < cls_used; k++) begin
      d  = int'(signed'(v)) - int'(signed'(cls_vec[k][pos]));
      ad = (d < 0) ? -d : d;
      if (ad > cfg_tol) cand_mask[k] = 1'b0;
    end
    if (pos + 1 < len) begin
      elem_pos = pos + 1;
      return;
    end
    // first surviving candidate wins
    hit = NCLS;
    for (int k = 0; k < cls_used; k++)
      if (hit == NCLS && cand_mask[k]) hit = k;
    res = '0;
    if (hit < NCLS) begin
      if (cls_cnt[hit] != COUNT_MAX) cls_cnt[hit] = cls_cnt[hit] + 1'b1;
      res.class_index = IDX_W'(hit);
      res.class_count = cls_cnt[hit];
      rows_matched++;
      if (cls_cnt[hit] == COUNT_MAX) rows_saturated++;
    end else if (cls_used < NCLS) begin
      for (int j = 0; j < NLEN; j++) cls_vec[cls_used][j] = row_buf[j];
      cls_cnt[cls_used]  = 1;
      res.class_index    = IDX_W'(cls_used);
      res.class_count    = 1;
      res.is_new_class   = 1'b1;
      cls_used++;
      rows_new++;
    end else begin
      res.table_full = 1'b1;
      rows_full++;
    end
    elem_pos  = 0;
    cand_mask = '1;
    expected_classes.insert(expected_classes.size(), res);
  endtask

  // Input driver: holds a beat until accepted, then offers the next one
  label_beat_t next_beat;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_value <= '0;
      drv_sos   <= 1'b0;
    end else begin
      if (drv_valid && label_bus.ready) begin
        classify_element(drv_value, drv_sos);
        beats_in++;
      end
      if (!drv_valid || label_bus.ready) begin
        if (label_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = label_backlog.pop_front();
          drv_valid <= 1'b1;
          drv_value <= next_beat.value;
          drv_sos   <= next_beat.sos;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls, or a long hold when asked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      rcv_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Output monitor: each result beat against the oldest expectation
  lci_res_t seen_class, want_class;
  always @(posedge clk_i) begin
    if (rst_ni && class_bus.valid && rcv_ready) begin
      seen_class.class_index  = class_bus.class_index;
      seen_class.is_new_class = class_bus.is_new_class;
      seen_class.class_count  = class_bus.class_count;
      seen_class.table_full   = class_bus.table_full;
      if (expected_classes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result beat with nothing expected: idx=%0d new=%0b cnt=%0d full=%0b",
                   $time, seen_class.class_index, seen_class.is_new_class,
                   seen_class.class_count, seen_class.table_full);
      end else begin
        want_class = expected_classes.pop_front();
        if (seen_class !== want_class) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch exp idx=%0d new=%0b cnt=%0d full=%0b, got idx=%0d new=%0b cnt=%0d full=%0b",
                     $time, want_class.class_index, want_class.is_new_class,
                     want_class.class_count, want_class.table_full,
                     seen_class.class_index, seen_class.is_new_class,
                     seen_class.class_count, seen_class.table_full);
        end
      end
    end
  end

  // Wait until the block is drained, then let it go quiet
  task automatic settle();
    while (label_backlog.size() != 0 || drv_valid || expected_classes.size() != 0)
      @(negedge clk_i);
    repeat (LAT_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_LABEL_LENGTH) cfg_len = data[LEN_W-1:0];
    else                         cfg_tol = data[TOL_W-1:0];
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Both registers; a longer row must open a new data set
  task automatic configure(input int len, input int tol);
    int unsigned eff;
    write_reg(CFG_LABEL_LENGTH, {11'($urandom_range(0, 2047)), 4'(len)});
    write_reg(CFG_MATCH_TOL, 15'(tol));
    eff = (len == 0) ? 1 : ((len > NLEN) ? NLEN : len);
    if (eff > gen_len) force_start = 1'b1;
    gen_len = eff;
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic push_beat(input logic [LABEL_W-1:0] value, input logic sos);
    label_beat_t b;
    b.value     = value;
    b.sos       = sos | force_start;
    force_start = 1'b0;
    label_backlog.insert(label_backlog.size(), b);
  endtask

  task automatic push_row(input row_t r, input logic sos);
    for (int j = 0; j < gen_len; j++) push_beat(r[j], sos && (j == 0));
  endtask

  function automatic logic [LABEL_W-1:0] draw_label();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return LABEL_W'($urandom);
    endcase
  endfunction

  // Mostly whole rows near earlier rows, some fresh, some cut short
  task automatic run_mixed_phase(input int budget);
    row_t        base, row;
    int          n, pick, cut, span;
    logic        sos;
    n = 0;
    palette.delete();
    while (n < budget) begin
      sos  = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 8 && gen_len > 1) begin
        // partial row, then a start lands in mid-row
        cut = $urandom_range(1, gen_len - 1);
        for (int j = 0; j < cut; j++) push_beat(draw_label(), 1'b0);
        n  += cut;
        sos = 1'b1;
      end else if (pick < 11) begin
        sos = 1'b1;
      end
      if (sos) palette.delete();
      if (palette.size() != 0 && $urandom_range(0, 99) < 55) begin
        base = palette[$urandom_range(0, palette.size() - 1)];
        span = int'(cfg_tol) + 1;
        for (int j = 0; j < NLEN; j++) begin
          row[j] = base[j];
          if ($urandom_range(0, 1))
            row[j] = base[j] + LABEL_W'($urandom_range(0, 2 * span) - span);
        end
      end else begin
        for (int j = 0; j < NLEN; j++) row[j] = draw_label();
      end
      push_row(row, sos);
      n += gen_len;
      if (palette.size() < 24) palette.insert(palette.size(), row);
    end
  endtask

  // Main sequence
  initial begin
    int len_pick, tol_pick;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: length one, zero tolerance; fill the table past full
    set_idle(32, 32);
    push_beat(16'h8000, 1'b1);
    push_beat(16'h7fff, 1'b0);
    for (int k = 2; k < 17; k++) push_beat(LABEL_W'(k * 1000 - 9000), 1'b0);
    push_beat(16'h8000, 1'b0);

    // Widest differences against the widest tolerance
    configure(2, 32767);
    push_beat(16'h8000, 1'b0);
    push_beat(16'h7fff, 1'b0);
    push_beat(16'h7fff, 1'b0);
    push_beat(16'h8000, 1'b0);

    // Row length cut while a row is open
    configure(4, 0);
    push_beat(16'h0100, 1'b0);
    push_beat(16'h0200, 1'b0);
    configure(2, 0);
    push_beat(16'h0300, 1'b0);

    // Zero length acts as one
    configure(0, 1);
    push_beat(16'h0300, 1'b0);
    settle();

    // Random phases over lengths, tolerances and idle mixes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       begin len_pick = 1;  tol_pick = 0;     end
        1:       begin len_pick = 8;  tol_pick = 0;     end
        2:       begin len_pick = 0;  tol_pick = 32767; end
        3:       begin len_pick = 15; tol_pick = 256;   end
        4:       begin len_pick = 2;  tol_pick = 0;     end
        5:       begin len_pick = 3;  tol_pick = $urandom_range(0, 64); end
        6:       begin len_pick = 8;  tol_pick = 32767; end
        default: begin
          len_pick = $urandom_range(0, 15);
          case ($urandom_range(0, 3))
            0:       tol_pick = 0;
            1:       tol_pick = $urandom_range(1, 512);
            2:       tol_pick = $urandom_range(0, 32767);
            default: tol_pick = 32767;
          endcase
        end
      endcase
      configure(len_pick, tol_pick);
      case (ph % 4)
        0:       set_idle(0, 0);
        1:       set_idle(67, 0);
        2:       set_idle(0, 67);
        default: set_idle(32, 32);
      endcase
      if (ph == 4) hold_asked++;
      run_mixed_phase(160);
      settle();
    end

    repeat (4 * LAT_CYCLES) @(negedge clk_i);
    fail_count += expected_classes.size();

    $display("covered %0d label beats, %0d rows: %0d new, %0d matched, %0d full, %0d saturated",
             beats_in, rows_new + rows_matched + rows_full, rows_new, rows_matched,
             rows_full, rows_saturated);
    $display("%0d register writes, lengths 0..15, tolerance 0..32767, four idle mixes, one long hold",
             cfg_writes);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
